>>> hdl/kti_pkg.sv
// Shared types and constants of the keyframe track interpolator.
package kti_pkg;

  localparam int KEYS_DEF = 64;

  localparam int TIME_W  = 24;  // unsigned Q16.8 time
  localparam int VAL_W   = 32;  // signed Q16.16 component
  localparam int FRAC_W  = 16;  // fraction bits of the blend factor
  localparam int FACT_W  = FRAC_W + 1;  // factor spans 0 .. 1.0 inclusive
  localparam int KIDX_W  = 6;
  localparam int CNT_W   = 7;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [FACT_W-1:0] ONE_Q16 = FACT_W'(1) << FRAC_W;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [PADDR_W-3:0] REG_KEY_COUNT = '0;

  typedef struct packed {
    logic                     opcode;
    logic [KIDX_W-1:0]        key_index;
    logic [TIME_W-1:0]        key_time;
    logic signed [VAL_W-1:0]  key_x;
    logic signed [VAL_W-1:0]  key_y;
    logic signed [VAL_W-1:0]  key_z;
    logic [TIME_W-1:0]        query_time;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  out_x;
    logic signed [VAL_W-1:0]  out_y;
    logic signed [VAL_W-1:0]  out_z;
    logic [KIDX_W-1:0]        segment_index;
    logic                     factor_forced;
  } out_word_t;

  // sequencing of the bit-serial blend lanes
  typedef struct packed {
    logic load;
    logic step;
    logic last;
  } lerp_ctl_t;

endpackage

>>> hdl/kti_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/kti_div.sv
// Restoring divider: (num << 16) / span, one quotient bit per cycle, num <= span.
module kti_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [kti_pkg::TIME_W-1:0]   num_i,
  input  logic [kti_pkg::TIME_W-1:0]   span_i,
  output logic [kti_pkg::FACT_W-1:0]   quot_o,
  output logic                         done_o
);
  import kti_pkg::*;

  localparam int SW = $clog2(FACT_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [SW-1:0]     cnt_q, cnt_d;
  logic [TIME_W:0]   rem_q, rem_d;
  logic [TIME_W-1:0] span_q, span_d;
  logic [FACT_W-1:0] quot_q, quot_d;
  logic              ge;
  logic [TIME_W:0]   rem_sub;

  always_comb begin
    ge      = rem_q >= {1'b0, span_q};
    rem_sub = ge ? (rem_q - {1'b0, span_q}) : rem_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    span_d  = span_q;
    quot_d  = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = {1'b0, num_i};
      span_d = span_i;
      quot_d = '0;
    end else if (busy_q) begin
      quot_d = {quot_q[FACT_W-2:0], ge};
      rem_d  = {rem_sub[TIME_W-1:0], 1'b0};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == SW'(FACT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    span_q <= span_d;
    quot_q <= quot_d;
  end

  assign quot_o = quot_q;
  assign done_o = done_q;

endmodule

>>> hdl/kti_lerp.sv
// One blend lane: a + floor((b - a) * f / 2^16), factor taken one bit per cycle.
module kti_lerp (
  input  logic                              clk_i,
  input  kti_pkg::lerp_ctl_t                ctl_i,
  input  logic signed [kti_pkg::VAL_W-1:0]  a_i,
  input  logic signed [kti_pkg::VAL_W-1:0]  b_i,
  input  logic [kti_pkg::FACT_W-1:0]        f_i,
  output logic signed [kti_pkg::VAL_W-1:0]  res_o
);
  import kti_pkg::*;

  localparam int DW = VAL_W + 1;
  localparam int PW = VAL_W + 2;

  logic signed [VAL_W-1:0] a_q, a_d;
  logic signed [DW-1:0]    delta_q, delta_d;
  logic signed [PW-1:0]    acc_q, acc_d;
  logic signed [PW-1:0]    sum;
  logic [FACT_W-1:0]       f_q, f_d;

  // LSB first; each partial sum drops one bit (floor), the final bit is kept unshifted
  always_comb begin
    sum     = acc_q + (f_q[0] ? PW'(delta_q) : PW'(0));
    a_d     = a_q;
    delta_d = delta_q;
    acc_d   = acc_q;
    f_d     = f_q;
    if (ctl_i.load) begin
      a_d     = a_i;
      delta_d = DW'(b_i) - DW'(a_i);
      acc_d   = '0;
      f_d     = f_i;
    end else if (ctl_i.step) begin
      f_d   = f_q >> 1;
      acc_d = ctl_i.last ? sum : (sum >>> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    delta_q <= delta_d;
    acc_q   <= acc_d;
    f_q     <= f_d;
  end

  assign res_o = VAL_W'(PW'(a_q) + acc_q);

endmodule

>>> hdl/keyframe_track_interpolator_unit.sv
// Top level of the keyframe track interpolator: key store, segment search and sequencer.
//
// Usage:
//  - Input words (in_valid_i / in_stall_o) either write one key (time + xyz vector)
//    into slot key_index, or query the track at query_time. A word moves at an edge
//    with valid high and stall low.
//  - A write gives no output word. A query gives one output word
//    (out_valid_o / out_stall_i): the interpolated vector, the start key of the chosen
//    segment and a flag telling that the blend factor was clamped to one.
//  - key_count (APB register at byte 0) sets the number of valid keys; write it only
//    while the block is idle. Reset sets it to one. Key slots are not cleared.
//  - A query passes through the search (reading one key time per cycle), the three fetch
//    states, a decide state, the serial divider, a load state, the bit-serial blend (three
//    lanes side by side) and the output register. Without a division the divider is skipped,
//    and a single key skips the search too. Queries are handled one at a time.
//  - The result waits in an output register; a new word is taken while it waits.
//    If the receiver stalls and the next result is ready, the sequencer holds it
//    and keeps in_stall_o high until the output register frees up.
//  - After reset the block is idle and takes words at once.
module keyframe_track_interpolator_unit #(
  parameter int KEYS = kti_pkg::KEYS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kti_pkg::PADDR_W-1:0]  paddr,
  input  logic [kti_pkg::PDATA_W-1:0]  pwdata,
  output logic [kti_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  // input words
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  kti_pkg::in_word_t            in_word_i,
  // output words
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output kti_pkg::out_word_t           out_word_o
);
  import kti_pkg::*;

  localparam int AW    = $clog2(KEYS);
  localparam int CW    = $clog2(KEYS + 1);
  localparam int MW    = $clog2(FACT_W);
  localparam int VEC_W = 3 * VAL_W;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SEARCH = 10'b0000000010,
    S_FETCH0 = 10'b0000000100,
    S_FETCH1 = 10'b0000001000,
    S_FETCH2 = 10'b0000010000,
    S_DECIDE = 10'b0000100000,
    S_DIV    = 10'b0001000000,
    S_LOAD   = 10'b0010000000,
    S_MUL    = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  key_count_q, key_count_d;
  logic [CW-1:0]     cnt_eff;
  logic [CW-1:0]     cnt_q, cnt_d;         // key count latched per query
  logic [TIME_W-1:0] qt_q, qt_d;
  logic [CW-1:0]     idx_q, idx_d;         // next time RAM address in search
  logic [CW-1:0]     cmp_idx_q, cmp_idx_d; // address whose data is on the read port
  logic              cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]     seg_q, seg_d;
  logic [TIME_W-1:0] t1_q, t1_d, t2_q, t2_d;
  logic [VEC_W-1:0]  va_q, va_d, vb_q, vb_d;
  logic [FACT_W-1:0] f_q, f_d;
  logic              forced_q, forced_d;
  logic [MW-1:0]     mul_cnt_q, mul_cnt_d;
  logic              out_vld_q, out_vld_d;
  out_word_t         out_q, out_d;

  logic              in_acc;
  logic              cfg_hit, cfg_wr;
  logic              single;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [TIME_W-1:0] t_rdata;
  logic [VEC_W-1:0]  v_rdata;
  logic [TIME_W-1:0] num, span;
  logic              div_start, div_done;
  logic [FACT_W-1:0] div_quot;
  logic              out_load;
  lerp_ctl_t         lctl;
  logic signed [VAL_W-1:0] lane_res [3];

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[PADDR_W-1:2] == REG_KEY_COUNT);
  assign cfg_wr  = psel & penable & pwrite & cfg_hit;
  assign prdata  = cfg_hit ? PDATA_W'(key_count_q) : '0;
  assign key_count_d = cfg_wr ? pwdata[CNT_W-1:0] : key_count_q;

  // zero counts as one, anything above the store depth saturates
  always_comb begin
    if (key_count_q == '0) begin
      cnt_eff = CW'(1);
    end else if (int'(key_count_q) > KEYS) begin
      cnt_eff = CW'(KEYS);
    end else begin
      cnt_eff = CW'(key_count_q);
    end
  end

  // ---------------- key store ----------------
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign wr_en      = in_acc && (in_word_i.opcode == OP_WRITE)
                      && (int'(in_word_i.key_index) < KEYS);
  assign wr_addr    = AW'(in_word_i.key_index);

  always_comb begin
    case (state_q)
      S_SEARCH: rd_addr = AW'(idx_q);
      S_FETCH1: rd_addr = AW'(seg_q + 1'b1);
      default:  rd_addr = seg_q;
    endcase
  end

  kti_ram #(.WIDTH(TIME_W), .DEPTH(KEYS)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (in_word_i.key_time),
    .raddr_i (rd_addr),
    .rdata_o (t_rdata)
  );

  kti_ram #(.WIDTH(VEC_W), .DEPTH(KEYS)) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i ({in_word_i.key_z, in_word_i.key_y, in_word_i.key_x}),
    .raddr_i (rd_addr),
    .rdata_o (v_rdata)
  );

  // ---------------- factor divider ----------------
  assign single = (cnt_q == CW'(1));
  assign num    = qt_q - t1_q;
  assign span   = t2_q - t1_q;

  kti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .span_i  (span),
    .quot_o  (div_quot),
    .done_o  (div_done)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    qt_d      = qt_q;
    idx_d     = idx_q;
    cmp_idx_d = cmp_idx_q;
    cmp_vld_d = cmp_vld_q;
    seg_d     = seg_q;
    t1_d      = t1_q;
    t2_d      = t2_q;
    va_d      = va_q;
    vb_d      = vb_q;
    f_d       = f_q;
    forced_d  = forced_q;
    mul_cnt_d = mul_cnt_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_word_i.opcode == OP_QUERY)) begin
          qt_d      = in_word_i.query_time;
          cnt_d     = cnt_eff;
          idx_d     = CW'(1);
          cmp_vld_d = 1'b0;
          seg_d     = '0;
          // a single key needs no search
          state_d   = (cnt_eff == CW'(1)) ? S_FETCH0 : S_SEARCH;
        end
      end
      S_SEARCH: begin
        // one time read issued per cycle, compared in the next cycle
        idx_d     = idx_q + 1'b1;
        cmp_idx_d = idx_q;
        cmp_vld_d = 1'b1;
        if (cmp_vld_q) begin
          if (qt_q < t_rdata) begin
            seg_d   = AW'(cmp_idx_q - 1'b1);
            state_d = S_FETCH0;
          end else if (cmp_idx_q == cnt_q - 1'b1) begin
            seg_d   = '0;  // past the last key: fall back to segment zero
            state_d = S_FETCH0;
          end
        end
      end
      S_FETCH0: state_d = S_FETCH1;
      S_FETCH1: begin
        t1_d    = t_rdata;
        va_d    = v_rdata;
        state_d = S_FETCH2;
      end
      S_FETCH2: begin
        t2_d    = t_rdata;
        vb_d    = v_rdata;
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        f_d      = '0;
        forced_d = 1'b0;
        state_d  = S_LOAD;
        // a single key, before the segment start, or exactly at it with a nonzero span: start key
        if (!single && (t1_q <= qt_q) && ((num != '0) || (t2_q == t1_q))) begin
          if ((t2_q <= t1_q) || (num > span)) begin
            f_d      = ONE_Q16;
            forced_d = 1'b1;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          f_d     = div_quot;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        mul_cnt_d = '0;
        state_d   = S_MUL;
      end
      S_MUL: begin
        mul_cnt_d = mul_cnt_q + 1'b1;
        if (lctl.last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------- blend lanes ----------------
  assign lctl.load = (state_q == S_LOAD);
  assign lctl.step = (state_q == S_MUL);
  assign lctl.last = (state_q == S_MUL) && (mul_cnt_q == MW'(FACT_W - 1));

  for (genvar c = 0; c < 3; c++) begin : g_lane
    kti_lerp u_lerp (
      .clk_i (clk_i),
      .ctl_i (lctl),
      .a_i   (va_q[c*VAL_W +: VAL_W]),
      .b_i   (vb_q[c*VAL_W +: VAL_W]),
      .f_i   (f_q),
      .res_o (lane_res[c])
    );
  end

  // ---------------- output register ----------------
  always_comb begin
    out_d = out_q;
    if (out_load) begin
      out_d.out_x         = lane_res[0];
      out_d.out_y         = lane_res[1];
      out_d.out_z         = lane_res[2];
      out_d.segment_index = KIDX_W'(seg_q);
      out_d.factor_forced = forced_q;
    end
  end

  assign out_vld_d   = out_load | (out_vld_q & out_stall_i);
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      key_count_q <= CNT_W'(1);
      cmp_vld_q   <= 1'b0;
      out_vld_q   <= 1'b0;
      mul_cnt_q   <= '0;
      cnt_q       <= CW'(1);
      idx_q       <= '0;
      cmp_idx_q   <= '0;
    end else begin
      state_q     <= state_d;
      key_count_q <= key_count_d;
      cmp_vld_q   <= cmp_vld_d;
      out_vld_q   <= out_vld_d;
      mul_cnt_q   <= mul_cnt_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      cmp_idx_q   <= cmp_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qt_q     <= qt_d;
    seg_q    <= seg_d;
    t1_q     <= t1_d;
    t2_q     <= t2_d;
    va_q     <= va_d;
    vb_q     <= vb_d;
    f_q      <= f_d;
    forced_q <= forced_d;
    out_q    <= out_d;
  end

  // ---------------- assertions ----------------
  a_factor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (f_q <= ONE_Q16))
    else $error("blend factor above one");

  a_forced_is_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_MUL) && forced_q) |-> (f_q == ONE_Q16))
    else $error("clamped factor is not one");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_vld_q && out_stall_i))
    else $error("output word overwritten while stalled");

  a_seg_in_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FETCH0) && !single) |-> ((int'(seg_q) + 2) <= int'(cnt_q)))
    else $error("segment end key beyond key count");

endmodule
